[rtl/c2d_pkg.sv]
// Package for the 2D convolution output point engine.
// Holds item structs, register indexes, store sizes and small helpers.
package c2d_pkg;

  localparam int MaxInCh  = 16;
  localparam int MaxH     = 32;
  localparam int MaxW     = 32;
  localparam int MaxOutCh = 16;
  localparam int MaxK     = 7;

  localparam int ActDepth = MaxInCh * MaxH * MaxW;
  localparam int WgtDepth = MaxOutCh * MaxInCh * MaxK * MaxK;
  localparam int ActAw    = $clog2(ActDepth);
  localparam int WgtAw    = $clog2(WgtDepth);

  typedef enum logic [1:0] {
    MODE_ACT  = 2'd0,
    MODE_WGT  = 2'd1,
    MODE_BIAS = 2'd2,
    MODE_COMP = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_IN_CH   = 3'd0,
    REG_IN_H    = 3'd1,
    REG_IN_W    = 3'd2,
    REG_OUT_CH  = 3'd3,
    REG_KDIMS   = 3'd4,
    REG_STRIDES = 3'd5,
    REG_PADS    = 3'd6,
    REG_DILS    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] value;
    logic [3:0]         out_channel;
    logic [3:0]         in_channel;
    logic [4:0]         row;
    logic [4:0]         col;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic [3:0]         out_channel_echo;
    logic [4:0]         out_row;
    logic [4:0]         out_col;
    logic               out_of_range;
  } out_item_t;

  // Decoded geometry handed from the top level to the sequencer.
  typedef struct packed {
    logic [4:0] n_ic;
    logic [5:0] ih;
    logic [5:0] iw;
    logic [2:0] kh;
    logic [2:0] kw;
    logic [3:0] sh;
    logic [3:0] sw;
    logic [3:0] ph;
    logic [3:0] pw;
    logic [3:0] dh;
    logic [3:0] dw;
  } geom_t;

  // Clamp a kernel nibble to 1..MaxK.
  function automatic logic [2:0] kclamp(input logic [3:0] v);
    if (v == 4'd0) return 3'd1;
    if (v > 4'(MaxK)) return 3'(MaxK);
    return v[2:0];
  endfunction

  function automatic logic [3:0] min1(input logic [3:0] v);
    return (v == 4'd0) ? 4'd1 : v;
  endfunction

endpackage

[rtl/c2d_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module c2d_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/c2d_seq.sv]
// Tap sequencer: walks channels, kernel rows and columns for one point,
// issues store addresses and accumulates products. Uses c2d_pkg.
module c2d_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  c2d_pkg::geom_t      geom,
  input  logic [3:0]          oc,
  input  logic [4:0]          orow,
  input  logic [4:0]          ocol,
  output logic [c2d_pkg::ActAw-1:0] act_raddr,
  output logic [c2d_pkg::WgtAw-1:0] wgt_raddr,
  input  logic [15:0]         act_rdata,
  input  logic [15:0]         wgt_rdata,
  output logic                done,
  output logic signed [47:0]  acc
);
  import c2d_pkg::*;

  // Two drain states cover the RAM read and the product register, so the
  // last product is in the accumulator by the time done is raised.
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RUN  = 5'b00010,
    S_DRN  = 5'b00100,
    S_DRN2 = 5'b01000,
    S_END  = 5'b10000
  } st_t;

  st_t state, state_next;
  logic [3:0] c;
  logic [2:0] r, k;
  logic signed [10:0] ybase, xbase, y, x;
  logic last_tap, tap_ok;
  logic v1, v2;
  logic signed [31:0] prod;

  // Tap row and column positions including dilation.
  always_comb begin
    y = ybase + 11'(r * geom.dh);
    x = xbase + 11'(k * geom.dw);
    tap_ok = (y >= 0) && (y < $signed({5'd0, geom.ih})) &&
             (x >= 0) && (x < $signed({5'd0, geom.iw}));
    last_tap = ({1'b0, c} == geom.n_ic - 5'd1) && (r == geom.kh - 3'd1) &&
               (k == geom.kw - 3'd1);
    act_raddr = ActAw'({c, y[4:0], x[4:0]});
    wgt_raddr = WgtAw'((((32'(oc) * MaxInCh + 32'(c)) * MaxK + 32'(r)) * MaxK) + 32'(k));
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (go) state_next = S_RUN;
      S_RUN:  if (last_tap) state_next = S_DRN;
      S_DRN:  state_next = S_DRN2;
      S_DRN2: state_next = S_END;
      S_END:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Counters, read-valid pipe, product register and accumulator.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      state <= state_next;
      v1 <= (state == S_RUN) && tap_ok;
      v2 <= v1;
    end
    if (state == S_IDLE && go) begin
      c <= '0;
      r <= '0;
      k <= '0;
      acc <= '0;
      ybase <= 11'(orow * geom.sh) - 11'(geom.ph);
      xbase <= 11'(ocol * geom.sw) - 11'(geom.pw);
    end else if (state == S_RUN) begin
      if (k == geom.kw - 3'd1) begin
        k <= '0;
        if (r == geom.kh - 3'd1) begin
          r <= '0;
          c <= c + 4'd1;
        end else begin
          r <= r + 3'd1;
        end
      end else begin
        k <= k + 3'd1;
      end
    end
    prod <= $signed(wgt_rdata) * $signed(act_rdata);
    if (v2) acc <= acc + 48'(prod);
  end

  assign done = (state == S_END);

endmodule

[rtl/conv2d_output_point_engine.sv]
// 2D convolution output point engine: a load keeps busy high for one cycle.
// A compute item walks every channel and kernel tap, one tap a cycle through the
// activation and weight RAM read ports; out-of-range points skip the walk.
// One item at a time. Results strobe for one cycle; receiver cannot stall.
// Reset: registers to defaults, bias to zero, stores undefined until written.
module conv2d_output_point_engine (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  c2d_pkg::in_item_t    in_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [7:0]           cfg_data,
  output logic                 out_strobe,
  output c2d_pkg::out_item_t   out_item
);
  import c2d_pkg::*;

  logic [4:0] r_ic, r_oc;
  logic [5:0] r_ih, r_iw;
  logic [6:0] r_kd;
  logic [7:0] r_st, r_pd, r_dl;
  logic [31:0] bias [MaxOutCh];
  geom_t g;
  in_item_t cur;
  logic run, bsy;
  logic act_we, wgt_we, take;
  logic [ActAw-1:0] act_ra;
  logic [WgtAw-1:0] wgt_ra;
  logic [15:0] act_rd, wgt_rd;
  logic sdone, sgo;
  logic signed [47:0] sacc, tot;
  logic [9:0] rprod, cprod;
  logic signed [8:0] nh, nw;
  logic bad;

  assign take = start && !busy;
  assign busy = bsy;
  // Register writes never share an edge with an accepted item.
  assign cfg_ready = !busy && !start;

  function automatic logic [4:0] r_oc_c();
    return (r_oc == 0) ? 5'd1 : (r_oc > 5'(MaxOutCh) ? 5'(MaxOutCh) : r_oc);
  endfunction

  // Geometry decode and output extent check. A row is inside the output
  // when row * stride does not exceed the padded span left after the kernel.
  always_comb begin
    g.n_ic = (r_ic == 0) ? 5'd1 : (r_ic > 5'(MaxInCh) ? 5'(MaxInCh) : r_ic);
    g.ih = (r_ih == 0) ? 6'd1 : (r_ih > 6'(MaxH) ? 6'(MaxH) : r_ih);
    g.iw = (r_iw == 0) ? 6'd1 : (r_iw > 6'(MaxW) ? 6'(MaxW) : r_iw);
    g.kw = kclamp(r_kd[3:0]);
    g.kh = kclamp({1'b0, r_kd[6:4]});
    g.sw = min1(r_st[3:0]);
    g.sh = min1(r_st[7:4]);
    g.pw = r_pd[3:0];
    g.ph = r_pd[7:4];
    g.dw = min1(r_dl[3:0]);
    g.dh = min1(r_dl[7:4]);
    nh = $signed({3'd0, g.ih}) + $signed({4'd0, g.ph, 1'b0})
       - $signed(9'((g.kh - 3'd1) * g.dh + 1));
    nw = $signed({3'd0, g.iw}) + $signed({4'd0, g.pw, 1'b0})
       - $signed(9'((g.kw - 3'd1) * g.dw + 1));
    rprod = {5'd0, cur.row} * {6'd0, g.sh};
    cprod = {5'd0, cur.col} * {6'd0, g.sw};
    bad = ({1'b0, cur.out_channel} >= r_oc_c()) || (nh < 0) || (rprod > 10'(nh)) ||
          (nw < 0) || (cprod > 10'(nw));
    tot = sacc + 48'($signed(bias[cur.out_channel]));
  end

  assign act_we = take && in_item.mode == MODE_ACT;
  assign wgt_we = take && in_item.mode == MODE_WGT && in_item.row < 5'(MaxK)
                  && in_item.col < 5'(MaxK);

  c2d_ram #(.Width(16), .Depth(ActDepth)) u_act (
    .clk(clk), .we(act_we),
    .waddr(ActAw'({in_item.in_channel, in_item.row, in_item.col})),
    .wdata(in_item.value[15:0]), .raddr(act_ra), .rdata(act_rd));

  c2d_ram #(.Width(16), .Depth(WgtDepth)) u_wgt (
    .clk(clk), .we(wgt_we),
    .waddr(WgtAw'((((32'(in_item.out_channel) * MaxInCh + 32'(in_item.in_channel))
             * MaxK + 32'(in_item.row)) * MaxK) + 32'(in_item.col))),
    .wdata(in_item.value[15:0]), .raddr(wgt_ra), .rdata(wgt_rd));

  c2d_seq u_seq (
    .clk(clk), .rst(rst), .go(sgo), .geom(g), .oc(cur.out_channel),
    .orow(cur.row), .ocol(cur.col), .act_raddr(act_ra), .wgt_raddr(wgt_ra),
    .act_rdata(act_rd), .wgt_rdata(wgt_rd), .done(sdone), .acc(sacc));

  // Control: latch the item, run the sequencer, emit one result per compute item.
  always_ff @(posedge clk) begin
    if (take) cur <= in_item;
    if (rst) begin
      bsy <= 1'b0;
      run <= 1'b0;
      sgo <= 1'b0;
      out_strobe <= 1'b0;
      r_ic <= 5'd1; r_ih <= 6'd32; r_iw <= 6'd32; r_oc <= 5'd1;
      r_kd <= 7'd51; r_st <= 8'd17; r_pd <= 8'd17; r_dl <= 8'd17;
      for (int i = 0; i < MaxOutCh; i++) bias[i] <= '0;
    end else begin
      out_strobe <= 1'b0;
      sgo <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (reg_idx_t'(cfg_index))
          REG_IN_CH:   r_ic <= cfg_data[4:0];
          REG_IN_H:    r_ih <= cfg_data[5:0];
          REG_IN_W:    r_iw <= cfg_data[5:0];
          REG_OUT_CH:  r_oc <= cfg_data[4:0];
          REG_KDIMS:   r_kd <= cfg_data[6:0];
          REG_STRIDES: r_st <= cfg_data;
          REG_PADS:    r_pd <= cfg_data;
          REG_DILS:    r_dl <= cfg_data;
          default: ;
        endcase
      end
      if (take) begin
        if (in_item.mode == MODE_BIAS) bias[in_item.out_channel] <= in_item.value;
        bsy <= 1'b1;
      end else if (bsy && !run) begin
        if (cur.mode != MODE_COMP) begin
          bsy <= 1'b0;
        end else if (bad) begin
          out_strobe <= 1'b1;
          out_item <= '{0, cur.out_channel, cur.row, cur.col, 1'b1};
          bsy <= 1'b0;
        end else begin
          run <= 1'b1;
          sgo <= 1'b1;
        end
      end else if (run && sdone) begin
        run <= 1'b0;
        bsy <= 1'b0;
        out_strobe <= 1'b1;
        out_item.out_value <= (tot > 48'sh7FFFFFFF) ? 32'sh7FFFFFFF :
                              (tot < -48'sh80000000) ? 32'sh80000000 : tot[31:0];
        out_item.out_channel_echo <= cur.out_channel;
        out_item.out_row <= cur.row;
        out_item.out_col <= cur.col;
        out_item.out_of_range <= 1'b0;
      end
    end
  end

  // A result appears only while an item is in flight.
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    out_strobe |-> $past(busy)) else $error("result without item");
  // Sequencer runs only for compute items.
  a_run_comp: assert property (@(posedge clk) disable iff (rst)
    run |-> cur.mode == MODE_COMP) else $error("run on load item");
  // Out-of-range results carry zero.
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (out_strobe && out_item.out_of_range) |-> out_item.out_value == 0)
    else $error("nonzero out-of-range value");

endmodule
